FILE: rtl/banner_signature_matcher_macros.svh
// Assertion macros for the banner signature matcher.
`ifndef BANNER_SIGNATURE_MATCHER_MACROS_SVH
`define BANNER_SIGNATURE_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
`define BSM_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define BSM_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define BSM_ASSERT_IMPL(label, clk, rst, a, b)
`define BSM_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

FILE: rtl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Signature table, score constants and the scoring word type.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int PAT_BYTES    = 28;
  localparam int SEEN_MAX     = 64;
  localparam int LANES        = 8;
  localparam int HINT_BONUS   = 10;
  localparam int HINT_PENALTY = 20;

  typedef struct packed {
    logic [8*PAT_BYTES-1:0] text;   // right aligned, zero padded on the left
    logic [6:0]             base;
    logic [15:0]            hint;
  } sig_t;

  // scoring word handed from cell to cell
  typedef struct packed {
    logic [SEEN_MAX-1:0] seen;
    logic [15:0]         port;
    logic                found;
    logic [5:0]          idx;
    logic [6:0]          best;
  } score_word_t;

  function automatic sig_t mk(input logic [8*PAT_BYTES-1:0] t, input int b, input int h);
    sig_t s;
    s.text = t;
    s.base = 7'(b);
    s.hint = 16'(h);
    return s;
  endfunction

  // signature ROM; slots past the table are empty and never match
  function automatic sig_t sig_rom(input logic [5:0] i);
    sig_t s;
    s = '0;
    case (i)
      6'd0:  s = mk({"Apa", "che/"}, 95, 80);
      6'd1:  s = mk({"ngi", "nx/"}, 95, 80);
      6'd2:  s = mk({"Microsoft", "-IIS/"}, 95, 80);
      6'd3:  s = mk("lighttpd/", 90, 80);
      6'd4:  s = mk("Cherokee/", 85, 80);
      6'd5:  s = mk("HTTP/1.", 70, 80);
      6'd6:  s = mk("Server: ", 60, 80);
      6'd7:  s = mk({"SSH-2.0-Op", "enSSH_"}, 95, 22);
      6'd8:  s = mk("SSH-2.0", 90, 22);
      6'd9:  s = mk("SSH-1.", 85, 22);
      6'd10: s = mk({"220 (vs", "FTPd"}, 95, 21);
      6'd11: s = mk({"220 Pro", "FTPD"}, 95, 21);
      6'd12: s = mk({"220 File", "Zilla Server"}, 90, 21);
      6'd13: s = mk("220 Microsoft FTP Service", 85, 21);
      6'd14: s = mk("220 ", 70, 21);
      6'd15: s = mk("220 ", 80, 25);
      6'd16: s = mk("ESMTP", 85, 25);
      6'd17: s = mk("Postfix", 90, 25);
      6'd18: s = mk("Sendmail", 90, 25);
      6'd19: s = mk("Microsoft ESMTP MAIL Service", 85, 25);
      6'd20: s = mk({"My", "SQL"}, 90, 3306);
      6'd21: s = mk({"Postgre", "SQL"}, 90, 5432);
      6'd22: s = mk("Microsoft SQL Server", 90, 1433);
      6'd23: s = mk({"Ora", "cle"}, 85, 1521);
      6'd24: s = mk({"Mongo", "DB"}, 85, 27017);
      6'd25: s = mk({"Red", "is"}, 85, 6379);
      6'd26: s = mk("POP3", 85, 110);
      6'd27: s = mk("IMAP", 85, 143);
      6'd28: s = mk({"Dove", "cot"}, 90, 143);
      6'd29: s = mk("BIND", 90, 53);
      6'd30: s = mk("dnsmasq", 85, 53);
      6'd31: s = mk("Telnet", 80, 23);
      6'd32: s = mk("SNMP", 80, 161);
      6'd33: s = mk("NTP", 75, 123);
      6'd34: s = mk("LDAP", 80, 389);
      6'd35: s = mk("HTTPS", 85, 443);
      6'd36: s = mk("FTPS", 80, 990);
      6'd37: s = mk("SMTPS", 80, 465);
      6'd38: s = mk("POP3S", 80, 995);
      6'd39: s = mk("IMAPS", 80, 993);
      6'd40: s = mk("RDP", 80, 3389);
      6'd41: s = mk("VNC", 85, 5900);
      6'd42: s = mk({"Team", "Viewer"}, 75, 5938);
      6'd43: s = mk("SMB", 80, 445);
      6'd44: s = mk("NetBIOS", 75, 139);
      6'd45: s = mk("NFS", 75, 2049);
      6'd46: s = mk("Squid", 85, 3128);
      6'd47: s = mk("SOCKS", 75, 1080);
      6'd48: s = mk({"Mine", "craft"}, 80, 25565);
      6'd49: s = mk({"Ste", "am"}, 75, 27015);
      6'd50: s = mk("SNMP", 80, 161);
      6'd51: s = mk({"Zab", "bix"}, 75, 10050);
      6'd52: s = mk("Nagios", 75, 5666);
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/bsm_score_cell.sv
// ----------------------------------------------------------------------------
// bsm_score_cell
// One scoring cell: scores its group of signatures and passes the best on.
// ----------------------------------------------------------------------------
module bsm_score_cell import bsm_pkg::*; #(
  parameter int CELL_ID       = 0,
  parameter int PATTERN_COUNT = 53
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  score_word_t up_word,
  output logic        dn_valid,
  input  logic        dn_ready,
  output score_word_t dn_word
);

  score_word_t word_next;
  logic        valid;
  score_word_t word;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_word  = word;

  // score each lane, strictly higher wins so ties keep the lower index
  always_comb begin
    sig_t       s;
    logic [7:0] score;
    int         i;
    word_next = up_word;
    for (int e = 0; e < LANES; e++) begin
      i = CELL_ID * LANES + e;
      s = sig_rom(6'(i));
      score = {1'b0, s.base};
      if (s.hint == up_word.port) begin
        score = score + 8'(HINT_BONUS);
      end else if (s.hint != 16'd0) begin
        score = score - 8'(HINT_PENALTY);
      end
      if (i < PATTERN_COUNT && up_word.seen[i] && score > {1'b0, word_next.best}) begin
        word_next.best  = score[6:0];
        word_next.idx   = 6'(i);
        word_next.found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      word <= word_next;
    end
  end

endmodule

FILE: rtl/banner_signature_matcher.sv
// A result passes through the NCELL registered scoring cells after its last byte is taken (7 at 53 patterns).
// Throughput: one byte per cycle while in_stall is low, set by the parallel window compare on each byte.
// Scoring runs as a chain of registered cells, eight signatures per cell.
// Reset (rst, synchronous): clears window, seen flags, zero mark and all cell valids.
// ----------------------------------------------------------------------------
// banner_signature_matcher
// Byte window compare against the signature ROM with a chained scoring pipe.
// ----------------------------------------------------------------------------
`include "banner_signature_matcher_macros.svh"
module banner_signature_matcher import bsm_pkg::*; #(
  parameter int WINDOW_BYTES  = 28,
  parameter int PATTERN_COUNT = 53
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  banner_byte,
  input  logic        last_byte,
  input  logic [15:0] port_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        match_found,
  output logic [5:0]  pattern_index,
  output logic [6:0]  best_score
);

  localparam int NCELL = (PATTERN_COUNT + LANES - 1) / LANES;

  logic [7:0]               recent [WINDOW_BYTES-1];
  logic [PATTERN_COUNT-1:0] seen;
  logic [PATTERN_COUNT-1:0] seen_next;
  logic [PATTERN_COUNT-1:0] hits;
  logic                     zero_seen;
  logic                     fire;
  logic                     scan;

  logic        c_valid [NCELL+1];
  logic        c_ready [NCELL+1];
  score_word_t c_word  [NCELL+1];

  assign in_stall = !c_ready[0];
  assign fire     = in_valid && !in_stall;
  assign scan     = !zero_seen && banner_byte != 8'd0;

  // compare every signature against the window ending at the current byte
  always_comb begin
    sig_t       s;
    logic [7:0] pb;
    logic [7:0] wb;
    for (int p = 0; p < PATTERN_COUNT; p++) begin
      s = sig_rom(6'(p));
      hits[p] = s.text != '0;
      for (int j = 0; j < PAT_BYTES; j++) begin
        pb = s.text[8*j +: 8];
        wb = (j == 0) ? banner_byte : recent[(j == 0) ? 0 : j-1];
        if (pb != 8'd0 && pb != wb) begin
          hits[p] = 1'b0;
        end
      end
    end
    seen_next = scan ? (seen | hits) : seen;
  end

  // window, flags and zero mark; cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      for (int k = 0; k < WINDOW_BYTES-1; k++) begin
        recent[k] <= 8'd0;
      end
      seen      <= '0;
      zero_seen <= 1'b0;
    end else if (fire) begin
      if (scan) begin
        recent[0] <= banner_byte;
        for (int k = 1; k < WINDOW_BYTES-1; k++) begin
          recent[k] <= recent[k-1];
        end
      end
      if (!zero_seen && banner_byte == 8'd0) begin
        zero_seen <= 1'b1;
      end
      seen <= seen_next;
    end
  end

  // head of the scoring chain
  assign c_valid[0]       = in_valid && last_byte;
  assign c_word[0].seen   = SEEN_MAX'(seen_next);
  assign c_word[0].port   = port_number;
  assign c_word[0].found  = 1'b0;
  assign c_word[0].idx    = 6'd0;
  assign c_word[0].best   = 7'd0;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    bsm_score_cell #(
      .CELL_ID       (c),
      .PATTERN_COUNT (PATTERN_COUNT)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (c_valid[c]),
      .up_ready (c_ready[c]),
      .up_word  (c_word[c]),
      .dn_valid (c_valid[c+1]),
      .dn_ready (c_ready[c+1]),
      .dn_word  (c_word[c+1])
    );
  end

  assign c_ready[NCELL] = !out_stall;
  assign out_valid      = c_valid[NCELL];
  assign match_found    = c_word[NCELL].found;
  assign pattern_index  = c_word[NCELL].idx;
  assign best_score     = c_word[NCELL].best;

  `BSM_ASSERT_IMPL(a_none_zero, clk, rst, out_valid && !match_found, pattern_index == 6'd0 && best_score == 7'd0)
  `BSM_ASSERT_IMPL(a_found_score, clk, rst, out_valid && match_found, best_score >= 7'd40)
  `BSM_ASSERT_NEXT(a_clear_after_last, clk, rst, fire && last_byte, seen == '0 && !zero_seen)

endmodule
